[rtl/core/assert_macros.svh]
// assertion macros shared by the crosspoint driver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define HKM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define HKM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/hkm_pkg.sv]
// types, codes and key translation table for the crosspoint driver
package hkm_pkg;

    // request codes
    typedef enum logic [1:0] {
        REQ_KEY_DOWN   = 2'd0,
        REQ_KEY_UP     = 2'd1,
        REQ_DISCONNECT = 2'd2,
        REQ_EMERGENCY  = 2'd3
    } t_req_type;

    // crosspoint drive codes
    typedef enum logic [1:0] {
        OP_NONE        = 2'd0,
        OP_PRESS       = 2'd1,
        OP_RELEASE     = 2'd2,
        OP_RELEASE_ALL = 2'd3
    } t_drive_op;

    // work kinds passed from the front to the back
    typedef enum logic [2:0] {
        CMD_NOOP,
        CMD_PRESS_HALT,
        CMD_RELEASE_HALT,
        CMD_RELEASE_ALL,
        CMD_TAP,
        CMD_BKSP_MACRO
    } t_cmd_kind;

    typedef logic [2:0] t_plane;
    typedef logic [5:0] t_addr;

    typedef struct packed {
        t_cmd_kind kind;
        t_plane    plane;
        t_addr     addr;
    } t_cmd;

    typedef struct packed {
        t_drive_op op;
        t_addr     addr;
        logic      last;
    } t_res;

    localparam t_plane PL_DEF   = 3'd0;
    localparam t_plane PL_GREEN = 3'd1;
    localparam t_plane PL_RED   = 3'd2;
    localparam t_plane PL_BLUE  = 3'd3;
    localparam t_plane PL_WORDS = 3'd4;

    localparam logic [7:0] MOD_CTRL  = 8'h11;
    localparam logic [7:0] MOD_SHIFT = 8'h22;
    localparam logic [7:0] KEY_A     = 8'h04;
    localparam logic [7:0] KEY_Z     = 8'h1D;
    localparam logic [7:0] KEY_F1    = 8'h3A;
    localparam logic [7:0] KEY_F12   = 8'h45;
    localparam logic [7:0] KEY_ESC   = 8'h29;
    localparam logic [7:0] KEY_BKSP  = 8'h2A;

    localparam t_addr ADDR_HALT  = 6'd2;   // row 0 col 2
    localparam t_addr ADDR_GREEN = 6'd40;  // row 5 col 0
    localparam t_addr ADDR_LEFT  = 6'd25;  // row 3 col 1
    localparam t_addr ADDR_ERASE = 6'd34;  // row 4 col 2

    localparam int Q_DEPTH = 2;

    // matrix position to crosspoint address
    function automatic t_addr pos(logic [2:0] row, logic [1:0] col);
        return {row, 1'b0, col};
    endfunction

    function automatic t_cmd tap(t_plane plane, t_addr addr);
        t_cmd c;
        c.kind  = CMD_TAP;
        c.plane = plane;
        c.addr  = addr;
        return c;
    endfunction

    function automatic t_cmd miss();
        t_cmd c;
        c.kind  = CMD_NOOP;
        c.plane = PL_DEF;
        c.addr  = '0;
        return c;
    endfunction

    // usage and modifiers to plane and target, or a no-op on a miss
    function automatic t_cmd lookup_key(logic [7:0] u, logic [7:0] mods);
        logic       ctrl;
        logic       sh;
        logic [4:0] i5;
        logic [8:0] prod;
        logic [3:0] g;
        logic [4:0] rem;
        logic [3:0] i4;
        t_cmd       c;
        ctrl = |(mods & MOD_CTRL);
        sh   = |(mods & MOD_SHIFT);
        i5   = 5'(u - KEY_A);
        // divide by three through a reciprocal, exact for 0..25
        prod = 9'(i5) * 9'd11;
        g    = prod[8:5];
        rem  = 5'(i5 - 5'({g, 1'b0}) - 5'(g));
        i4   = 4'(u - KEY_F1);
        c    = miss();
        if (ctrl) begin
            case (u)
                8'h3A: c = tap(PL_WORDS, pos(3'd0, 2'd0));
                8'h3B: c = tap(PL_WORDS, pos(3'd0, 2'd2));
                8'h3C: c = tap(PL_WORDS, pos(3'd0, 2'd3));
                8'h3D: c = tap(PL_WORDS, pos(3'd4, 2'd1));
                8'h3E: c = tap(PL_WORDS, pos(3'd4, 2'd3));
                8'h38: c = tap(PL_DEF, pos(3'd0, 2'd3));
                8'h25: c = sh ? tap(PL_DEF, pos(3'd1, 2'd3)) : miss();
                default: c = miss();
            endcase
        end else if (u >= KEY_A && u <= KEY_Z) begin
            c = tap(3'(PL_GREEN + rem[2:0]), pos(3'(3'd1 + {1'b0, g[3:2]}), g[1:0]));
        end else if (u >= KEY_F1 && u <= KEY_F12) begin
            c = tap(PL_WORDS, pos(3'(3'd1 + {1'b0, i4[3:2]}), i4[1:0]));
        end else begin
            case (u)
                8'h28: c = sh ? tap(PL_WORDS, pos(3'd0, 2'd0)) : tap(PL_DEF, pos(3'd0, 2'd0));
                8'h2C: c = tap(PL_DEF, pos(3'd4, 2'd0));
                8'h2A, 8'h4C: c = tap(PL_DEF, pos(3'd4, 2'd2));
                8'h48: c = tap(PL_DEF, pos(3'd0, 2'd1));
                8'h1E: c = sh ? tap(PL_BLUE, pos(3'd3, 2'd0)) : tap(PL_DEF, pos(3'd3, 2'd0));
                8'h1F: c = sh ? tap(PL_RED, pos(3'd3, 2'd3)) : tap(PL_DEF, pos(3'd3, 2'd1));
                8'h20: c = sh ? tap(PL_GREEN, pos(3'd4, 2'd3)) : tap(PL_DEF, pos(3'd3, 2'd2));
                8'h21: c = sh ? tap(PL_GREEN, pos(3'd4, 2'd0)) : tap(PL_DEF, pos(3'd2, 2'd0));
                8'h22: c = sh ? tap(PL_RED, pos(3'd4, 2'd3)) : tap(PL_DEF, pos(3'd2, 2'd1));
                8'h23: c = sh ? miss() : tap(PL_DEF, pos(3'd2, 2'd2));
                8'h24: c = sh ? tap(PL_GREEN, pos(3'd3, 2'd3)) : tap(PL_DEF, pos(3'd1, 2'd0));
                8'h25: c = sh ? tap(PL_BLUE, pos(3'd3, 2'd3)) : tap(PL_DEF, pos(3'd1, 2'd1));
                8'h26: c = sh ? tap(PL_GREEN, pos(3'd4, 2'd2)) : tap(PL_DEF, pos(3'd1, 2'd2));
                8'h27: c = sh ? tap(PL_BLUE, pos(3'd4, 2'd2)) : tap(PL_DEF, pos(3'd4, 2'd1));
                8'h2D: c = sh ? miss() : tap(PL_DEF, pos(3'd2, 2'd3));
                8'h2E: c = sh ? tap(PL_DEF, pos(3'd3, 2'd3)) : tap(PL_DEF, pos(3'd4, 2'd3));
                8'h2F: c = sh ? miss() : tap(PL_RED, pos(3'd0, 2'd3));
                8'h30: c = sh ? miss() : tap(PL_BLUE, pos(3'd0, 2'd3));
                8'h31: c = sh ? miss() : tap(PL_BLUE, pos(3'd0, 2'd1));
                8'h33: c = sh ? tap(PL_BLUE, pos(3'd4, 2'd3)) : tap(PL_RED, pos(3'd4, 2'd2));
                8'h34: c = sh ? tap(PL_RED, pos(3'd4, 2'd1)) : tap(PL_RED, pos(3'd3, 2'd1));
                8'h36: c = sh ? tap(PL_GREEN, pos(3'd4, 2'd1)) : tap(PL_RED, pos(3'd4, 2'd0));
                8'h37: c = sh ? tap(PL_BLUE, pos(3'd4, 2'd1)) : tap(PL_RED, pos(3'd3, 2'd2));
                8'h38: c = sh ? tap(PL_BLUE, pos(3'd4, 2'd0)) : tap(PL_RED, pos(3'd0, 2'd1));
                8'h50: c = tap(PL_GREEN, pos(3'd3, 2'd1));
                8'h4F: c = tap(PL_BLUE, pos(3'd3, 2'd1));
                8'h52: c = tap(PL_GREEN, pos(3'd3, 2'd2));
                8'h51: c = tap(PL_BLUE, pos(3'd3, 2'd2));
                8'h62: c = tap(PL_DEF, pos(3'd4, 2'd1));
                8'h59: c = tap(PL_DEF, pos(3'd3, 2'd0));
                8'h5A: c = tap(PL_DEF, pos(3'd3, 2'd1));
                8'h5B: c = tap(PL_DEF, pos(3'd3, 2'd2));
                8'h5C: c = tap(PL_DEF, pos(3'd2, 2'd0));
                8'h5D: c = tap(PL_DEF, pos(3'd2, 2'd1));
                8'h5E: c = tap(PL_DEF, pos(3'd2, 2'd2));
                8'h5F: c = tap(PL_DEF, pos(3'd1, 2'd0));
                8'h60: c = tap(PL_DEF, pos(3'd1, 2'd1));
                8'h61: c = tap(PL_DEF, pos(3'd1, 2'd2));
                8'h63: c = tap(PL_RED, pos(3'd3, 2'd2));
                8'h54: c = tap(PL_DEF, pos(3'd0, 2'd3));
                8'h55: c = tap(PL_DEF, pos(3'd1, 2'd3));
                8'h56: c = tap(PL_DEF, pos(3'd2, 2'd3));
                8'h57: c = tap(PL_DEF, pos(3'd3, 2'd3));
                8'h58: c = tap(PL_DEF, pos(3'd0, 2'd0));
                8'h67: c = tap(PL_DEF, pos(3'd4, 2'd3));
                default: c = miss();
            endcase
        end
        return c;
    endfunction

    // one result of a command at a given step
    function automatic t_res res_at(t_cmd cmd, logic [2:0] step);
        logic [1:0] pair;
        t_addr      sh_addr;
        t_res       r;
        pair    = step[2:1];
        sh_addr = {3'd5, 3'(cmd.plane - 3'd1)};
        r.op    = step[0] ? OP_RELEASE : OP_PRESS;
        r.addr  = '0;
        r.last  = 1'b1;
        unique case (cmd.kind)
            CMD_NOOP:         r.op = OP_NONE;
            CMD_PRESS_HALT:   begin
                r.op   = OP_PRESS;
                r.addr = ADDR_HALT;
            end
            CMD_RELEASE_HALT: begin
                r.op   = OP_RELEASE;
                r.addr = ADDR_HALT;
            end
            CMD_RELEASE_ALL:  r.op = OP_RELEASE_ALL;
            CMD_TAP:          begin
                if (cmd.plane != PL_DEF) begin
                    r.addr = (pair == 2'd0) ? sh_addr : cmd.addr;
                    r.last = (step == 3'd3);
                end else begin
                    r.addr = cmd.addr;
                    r.last = (step == 3'd1);
                end
            end
            CMD_BKSP_MACRO:   begin
                r.addr = (pair == 2'd0) ? ADDR_GREEN :
                         (pair == 2'd1) ? ADDR_LEFT : ADDR_ERASE;
                r.last = (step == 3'd5);
            end
            default:          r.op = OP_NONE;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/hkm_in_if.sv]
// keyboard event channel
interface hkm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [1:0] source_id;
    logic [7:0] key_usage;
    logic [7:0] modifier_bits;

    modport source (output valid, output req_type, output source_id, output key_usage,
                    output modifier_bits, input ready);
    modport sink   (input valid, input req_type, input source_id, input key_usage,
                    input modifier_bits, output ready);
endinterface

[rtl/core/hkm_out_if.sv]
// crosspoint drive result channel
interface hkm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] drive_op;
    logic [5:0] crosspoint_addr;
    logic       last_of_run;

    modport source (output valid, output drive_op, output crosspoint_addr,
                    output last_of_run, input ready);
    modport sink   (input valid, input drive_op, input crosspoint_addr,
                    input last_of_run, output ready);
endinterface

[rtl/core/hkm_front.sv]
// event classifier: halt holds, key table lookup and backspace macro select
module hkm_front #(
    parameter int SOURCE_COUNT = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hkm_in_if.sink        i_req,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_q_full,
    output logic          o_push,
    output hkm_pkg::t_cmd o_cmd
);
    import hkm_pkg::*;

    localparam int SRC_W = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;

    logic                    r_bksp_en;
    logic [SOURCE_COUNT-1:0] r_halt;
    logic [SOURCE_COUNT-1:0] n_halt;
    logic                    r_valid;
    t_cmd                    r_cmd;
    t_cmd                    n_cmd;
    logic                    accept;
    logic                    src_ok;
    logic [SRC_W-1:0]        src_idx;
    logic                    held;

    assign o_push      = r_valid && !i_q_full;
    assign o_cmd       = r_cmd;
    assign i_req.ready = !r_valid || o_push;
    assign accept      = i_req.valid && i_req.ready;
    assign src_ok      = int'(i_req.source_id) < SOURCE_COUNT;
    assign src_idx     = SRC_W'(i_req.source_id);
    assign held        = src_ok && r_halt[src_idx];

    // classify the event and update the halt holds
    always_comb begin
        n_halt = r_halt;
        n_cmd  = miss();
        unique case (i_req.req_type) inside
            REQ_KEY_DOWN: begin
                if (i_req.key_usage == KEY_ESC) begin
                    if (src_ok && !held) begin
                        n_cmd.kind      = CMD_PRESS_HALT;
                        n_halt[src_idx] = 1'b1;
                    end
                end else if (i_req.key_usage == KEY_BKSP && r_bksp_en) begin
                    n_cmd.kind = CMD_BKSP_MACRO;
                end else begin
                    n_cmd = lookup_key(i_req.key_usage, i_req.modifier_bits);
                end
            end
            REQ_KEY_UP, REQ_DISCONNECT: begin
                if ((i_req.req_type == REQ_DISCONNECT || i_req.key_usage == KEY_ESC) && held) begin
                    n_cmd.kind      = CMD_RELEASE_HALT;
                    n_halt[src_idx] = 1'b0;
                end
            end
            default: begin
                n_cmd.kind = CMD_RELEASE_ALL;
                n_halt     = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bksp_en <= 1'b0;
            r_halt    <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_bksp_en <= i_cfg_wr_data;
            end
            if (accept) begin
                r_halt  <= n_halt;
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    // classified command register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    `include "assert_macros.svh"

    `HKM_ASSERT_NEXT(a_emergency_clears, i_clk, i_rst_n,
        accept && i_req.req_type == REQ_EMERGENCY, r_halt == '0,
        "halt holds not cleared by emergency release")
    `HKM_ASSERT_NEXT(a_stalled_cmd_holds, i_clk, i_rst_n,
        r_valid && i_q_full, r_valid && $stable(r_cmd),
        "classified command lost while the queue is full")

endmodule

[rtl/core/hkm_queue.sv]
// short command queue between the classifier and the sequencer
module hkm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hkm_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output hkm_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import hkm_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (i_pop && !i_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `include "assert_macros.svh"

    `HKM_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into a full queue")
    `HKM_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && !o_valid), "pop from an empty queue")

endmodule

[rtl/core/hkm_back.sv]
// result sequencer: expands one command into its crosspoint results
module hkm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  hkm_pkg::t_cmd i_cmd,
    output logic          o_pop,
    hkm_out_if.source     o_res
);
    import hkm_pkg::*;

    logic [2:0] r_step;
    logic       r_out_valid;
    t_res       r_res;
    t_res       cur;
    logic       issue;

    assign cur   = res_at(i_cmd, r_step);
    assign issue = i_valid && (!r_out_valid || o_res.ready);
    assign o_pop = issue && cur.last;

    assign o_res.valid           = r_out_valid;
    assign o_res.drive_op        = r_res.op;
    assign o_res.crosspoint_addr = r_res.addr;
    assign o_res.last_of_run     = r_res.last;

    // step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_step      <= cur.last ? 3'd0 : 3'(r_step + 3'd1);
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output result register
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_res <= cur;
        end
    end

    `include "assert_macros.svh"

    `HKM_ASSERT_NEXT(a_stall_holds_step, i_clk, i_rst_n,
        r_out_valid && !o_res.ready, $stable(r_step),
        "sequencer advanced while the output was stalled")
    `HKM_ASSERT(a_step_in_range, i_clk, i_rst_n, r_step <= 3'd5,
        "sequencer step beyond the longest command")

endmodule

[rtl/core/hid_key_to_matrix_crosspoint.sv]
// top level: keyboard events in, key matrix crosspoint drive results out
//
// Usage: i_req carries keyboard events (key down, key up, disconnect,
// emergency release) from up to SOURCE_COUNT sources; o_res carries the
// crosspoint drive results, one per handshake, the final one of each event
// marked by last_of_run. Both channels use valid/ready. i_cfg_wr_en with
// i_cfg_wr_data writes the backspace macro enable; write it only when idle.
// Path: an event passes the classifier command register, a queue entry and
// the output result register. The sequencer gives one result per cycle
// while o_res is ready; an event yields 1 to 6 results (no-op, halt and
// release-all 1, a tap 2 or 4, the backspace macro 6); the classifier and
// a two-entry command queue keep taking events while the sequencer works.
// Reset: clears all halt holds, the macro enable and every pipeline stage.
// Stall: a result not taken holds in the output register; the sequencer,
// then the queue, then i_req.ready back off in turn, and nothing is lost.
module hid_key_to_matrix_crosspoint #(
    parameter int SOURCE_COUNT = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hkm_in_if.sink    i_req,
    hkm_out_if.source o_res,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data
);
    import hkm_pkg::*;

    logic q_full;
    logic push;
    t_cmd push_cmd;
    logic head_valid;
    t_cmd head_cmd;
    logic pop;

    // classifier
    hkm_front #(
        .SOURCE_COUNT(SOURCE_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // command queue
    hkm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    // sequencer
    hkm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

[verif/hkm_drive_checker.sv]
// checker for the crosspoint driver: predicts drive results per event and compares them
module hkm_drive_checker #(
    parameter int SOURCE_COUNT = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hkm_in_if    i_req,
    hkm_out_if   i_res,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    output int   o_mismatch_count,
    output int   o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import hkm_pkg::*;

    typedef struct packed {
        logic   hit;
        t_plane plane;
        t_addr  addr;
    } t_key_hit;

    logic [SOURCE_COUNT-1:0] halt_hold;
    logic                    bksp_macro;
    t_res                    drive_q[$];
    int                      mismatches = 0;

    // matrix position of a table entry
    function automatic t_key_hit hit_at(t_plane plane, int row, int col);
        t_key_hit h;
        h.hit   = 1'b1;
        h.plane = plane;
        h.addr  = 6'(row * 8 + col);
        return h;
    endfunction

    // key translation: usage and modifiers to plane and target position
    function automatic t_key_hit key_target(logic [7:0] u, logic [7:0] mods);
        logic     ctrl;
        logic     sh;
        int       idx;
        int       grp;
        t_key_hit h;
        ctrl = |(mods & MOD_CTRL);
        sh   = |(mods & MOD_SHIFT);
        h    = '0;
        if (ctrl) begin
            case (u)
                8'h3A: h = hit_at(PL_WORDS, 0, 0);
                8'h3B: h = hit_at(PL_WORDS, 0, 2);
                8'h3C: h = hit_at(PL_WORDS, 0, 3);
                8'h3D: h = hit_at(PL_WORDS, 4, 1);
                8'h3E: h = hit_at(PL_WORDS, 4, 3);
                8'h38: h = hit_at(PL_DEF, 0, 3);
                8'h25: if (sh) h = hit_at(PL_DEF, 1, 3);
                default: h = '0;
            endcase
        end else if (u >= KEY_A && u <= KEY_Z) begin
            // letters: three per key, plane picked by position in the group
            idx = int'(u) - int'(KEY_A);
            grp = idx / 3;
            h   = hit_at(3'(int'(PL_GREEN) + idx % 3), 1 + grp / 4, grp % 4);
        end else if (u >= KEY_F1 && u <= KEY_F12) begin
            idx = int'(u) - int'(KEY_F1);
            h   = hit_at(PL_WORDS, 1 + idx / 4, idx % 4);
        end else begin
            case (u)
                8'h28: h = sh ? hit_at(PL_WORDS, 0, 0) : hit_at(PL_DEF, 0, 0);
                8'h2C: h = hit_at(PL_DEF, 4, 0);
                8'h2A, 8'h4C: h = hit_at(PL_DEF, 4, 2);
                8'h48: h = hit_at(PL_DEF, 0, 1);
                8'h1E: h = sh ? hit_at(PL_BLUE, 3, 0) : hit_at(PL_DEF, 3, 0);
                8'h1F: h = sh ? hit_at(PL_RED, 3, 3) : hit_at(PL_DEF, 3, 1);
                8'h20: h = sh ? hit_at(PL_GREEN, 4, 3) : hit_at(PL_DEF, 3, 2);
                8'h21: h = sh ? hit_at(PL_GREEN, 4, 0) : hit_at(PL_DEF, 2, 0);
                8'h22: h = sh ? hit_at(PL_RED, 4, 3) : hit_at(PL_DEF, 2, 1);
                8'h23: h = sh ? '0 : hit_at(PL_DEF, 2, 2);
                8'h24: h = sh ? hit_at(PL_GREEN, 3, 3) : hit_at(PL_DEF, 1, 0);
                8'h25: h = sh ? hit_at(PL_BLUE, 3, 3) : hit_at(PL_DEF, 1, 1);
                8'h26: h = sh ? hit_at(PL_GREEN, 4, 2) : hit_at(PL_DEF, 1, 2);
                8'h27: h = sh ? hit_at(PL_BLUE, 4, 2) : hit_at(PL_DEF, 4, 1);
                8'h2D: h = sh ? '0 : hit_at(PL_DEF, 2, 3);
                8'h2E: h = sh ? hit_at(PL_DEF, 3, 3) : hit_at(PL_DEF, 4, 3);
                8'h2F: h = sh ? '0 : hit_at(PL_RED, 0, 3);
                8'h30: h = sh ? '0 : hit_at(PL_BLUE, 0, 3);
                8'h31: h = sh ? '0 : hit_at(PL_BLUE, 0, 1);
                8'h33: h = sh ? hit_at(PL_BLUE, 4, 3) : hit_at(PL_RED, 4, 2);
                8'h34: h = sh ? hit_at(PL_RED, 4, 1) : hit_at(PL_RED, 3, 1);
                8'h36: h = sh ? hit_at(PL_GREEN, 4, 1) : hit_at(PL_RED, 4, 0);
                8'h37: h = sh ? hit_at(PL_BLUE, 4, 1) : hit_at(PL_RED, 3, 2);
                8'h38: h = sh ? hit_at(PL_BLUE, 4, 0) : hit_at(PL_RED, 0, 1);
                8'h50: h = hit_at(PL_GREEN, 3, 1);
                8'h4F: h = hit_at(PL_BLUE, 3, 1);
                8'h52: h = hit_at(PL_GREEN, 3, 2);
                8'h51: h = hit_at(PL_BLUE, 3, 2);
                8'h62: h = hit_at(PL_DEF, 4, 1);
                8'h59: h = hit_at(PL_DEF, 3, 0);
                8'h5A: h = hit_at(PL_DEF, 3, 1);
                8'h5B: h = hit_at(PL_DEF, 3, 2);
                8'h5C: h = hit_at(PL_DEF, 2, 0);
                8'h5D: h = hit_at(PL_DEF, 2, 1);
                8'h5E: h = hit_at(PL_DEF, 2, 2);
                8'h5F: h = hit_at(PL_DEF, 1, 0);
                8'h60: h = hit_at(PL_DEF, 1, 1);
                8'h61: h = hit_at(PL_DEF, 1, 2);
                8'h63: h = hit_at(PL_RED, 3, 2);
                8'h54: h = hit_at(PL_DEF, 0, 3);
                8'h55: h = hit_at(PL_DEF, 1, 3);
                8'h56: h = hit_at(PL_DEF, 2, 3);
                8'h57: h = hit_at(PL_DEF, 3, 3);
                8'h58: h = hit_at(PL_DEF, 0, 0);
                8'h67: h = hit_at(PL_DEF, 4, 3);
                default: h = '0;
            endcase
        end
        return h;
    endfunction

    function automatic void add_drive(t_drive_op op, t_addr addr);
        t_res r;
        r.op   = op;
        r.addr = addr;
        r.last = 1'b0;
        drive_q.push_back(r);
    endfunction

    // plane shift tap first when off the default plane, then the target tap
    function automatic void add_tap(t_plane plane, t_addr addr);
        t_addr shift_addr;
        shift_addr = 6'(int'(ADDR_GREEN) + int'(plane) - 1);
        if (plane != PL_DEF) begin
            add_drive(OP_PRESS, shift_addr);
            add_drive(OP_RELEASE, shift_addr);
        end
        add_drive(OP_PRESS, addr);
        add_drive(OP_RELEASE, addr);
    endfunction

    // expected drive results of one keyboard event
    function automatic void predict_event(t_req_type req, logic [1:0] src, logic [7:0] u,
                                          logic [7:0] mods);
        int       start_n;
        logic     known;
        t_key_hit h;
        t_res     tail;
        start_n = drive_q.size();
        known   = int'(src) < SOURCE_COUNT;
        case (req)
            REQ_KEY_DOWN: begin
                if (u == KEY_ESC) begin
                    if (known && !halt_hold[src]) begin
                        halt_hold[src] = 1'b1;
                        add_drive(OP_PRESS, ADDR_HALT);
                    end
                end else if (u == KEY_BKSP && bksp_macro) begin
                    add_tap(PL_GREEN, ADDR_LEFT);
                    add_tap(PL_DEF, ADDR_ERASE);
                end else begin
                    h = key_target(u, mods);
                    if (h.hit) add_tap(h.plane, h.addr);
                end
            end
            REQ_KEY_UP, REQ_DISCONNECT: begin
                if ((req == REQ_DISCONNECT || u == KEY_ESC) && known) begin
                    if (halt_hold[src]) begin
                        halt_hold[src] = 1'b0;
                        add_drive(OP_RELEASE, ADDR_HALT);
                    end
                end
            end
            default: begin
                halt_hold = '0;
                add_drive(OP_RELEASE_ALL, '0);
            end
        endcase
        if (drive_q.size() == start_n) add_drive(OP_NONE, '0);
        // mark the final result of this event
        tail      = drive_q.pop_back();
        tail.last = 1'b1;
        drive_q.push_back(tail);
    endfunction

    // track events and results at each edge
    always @(posedge i_clk) begin : track
        t_res want;
        if (!i_rst_n) begin
            halt_hold  = '0;
            bksp_macro = 1'b0;
            drive_q.delete();
        end else begin
            if (i_cfg_wr_en) bksp_macro = i_cfg_wr_data;
            if (i_req.valid && i_req.ready) begin
                predict_event(t_req_type'(i_req.req_type), i_req.source_id, i_req.key_usage,
                              i_req.modifier_bits);
            end
            if (i_res.valid && i_res.ready) begin
                if (drive_q.size() == 0) begin
                    $error("unexpected drive result: drive_op %0d crosspoint_addr %0d",
                           i_res.drive_op, i_res.crosspoint_addr);
                    mismatches++;
                end else begin
                    want = drive_q.pop_front();
                    if (i_res.drive_op !== want.op) begin
                        $error("drive_op mismatch: expected %0d, actual %0d",
                               want.op, i_res.drive_op);
                        mismatches++;
                    end
                    if (i_res.crosspoint_addr !== want.addr) begin
                        $error("crosspoint_addr mismatch: expected %0d, actual %0d",
                               want.addr, i_res.crosspoint_addr);
                        mismatches++;
                    end
                    if (i_res.last_of_run !== want.last) begin
                        $error("last_of_run mismatch: expected %0d, actual %0d",
                               want.last, i_res.last_of_run);
                        mismatches++;
                    end
                end
            end
        end
        o_pending_count  <= drive_q.size();
        o_mismatch_count <= mismatches;
    end

endmodule

[verif/testbench.sv]
// testbench top: keyboard event stimulus, result receiver, watchdog and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hkm_pkg::*;

    localparam int SOURCES          = 4;
    localparam int HOLD_CYCLES      = 150;
    localparam int STALL_LIMIT      = 3000;
    localparam int EVENTS_PER_PHASE = 160;
    localparam int HOLD_AT_EVENT    = 40;

    logic i_clk;
    logic i_rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_req;
    logic hold_ack;
    int   hold_left;
    int   stall_cycles;
    int   mismatch_count;
    int   pending_count;

    hkm_in_if  req_bus ();
    hkm_out_if res_bus ();

    hid_key_to_matrix_crosspoint #(
        .SOURCE_COUNT(SOURCES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .o_res        (res_bus),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    hkm_drive_checker #(
        .SOURCE_COUNT(SOURCES)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_bus),
        .i_res           (res_bus),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .o_mismatch_count(mismatch_count),
        .o_pending_count (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            hold_left = 0;
            hold_ack  = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_bus.ready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES - 1;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // offer one event, with a random gap first, and wait until it is taken
    task automatic send_event(t_req_type req, logic [1:0] src, logic [7:0] u,
                              logic [7:0] mods);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_bus.valid         <= 1'b1;
        req_bus.req_type      <= req;
        req_bus.source_id     <= src;
        req_bus.key_usage     <= u;
        req_bus.modifier_bits <= mods;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // stop offering and wait until every expected result is out
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_macro_enable(logic value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed events: mapped keys, halt press and release, some noise
    task automatic send_random_event();
        int         pick;
        t_req_type  req;
        logic [1:0] src;
        logic [7:0] u;
        logic [7:0] mods;
        pick = $urandom_range(0, 99);
        src  = 2'($urandom_range(0, 3));
        u    = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0: mods = 8'h00;
            1: mods = $urandom_range(0, 1) ? 8'h02 : 8'h20;
            2: mods = $urandom_range(0, 1) ? 8'h01 : 8'h10;
            3: mods = 8'($urandom_range(0, 255)) | MOD_CTRL | MOD_SHIFT;
            default: mods = 8'($urandom_range(0, 255));
        endcase
        if (pick < 55) begin
            req = REQ_KEY_DOWN;
            if ($urandom_range(0, 3) != 0) u = 8'($urandom_range(KEY_A, 8'h67));
        end else if (pick < 65) begin
            req = REQ_KEY_DOWN;
            u   = KEY_ESC;
        end else if (pick < 68) begin
            req = REQ_KEY_DOWN;
            u   = KEY_BKSP;
        end else if (pick < 82) begin
            req = REQ_KEY_UP;
            if ($urandom_range(0, 3) != 0) u = KEY_ESC;
        end else if (pick < 92) begin
            req = REQ_DISCONNECT;
        end else if (pick < 96) begin
            req = REQ_EMERGENCY;
        end else begin
            req = t_req_type'($urandom_range(0, 3));
        end
        send_event(req, src, u, mods);
    endtask

    // stimulus and verdict
    initial begin
        req_bus.valid         = 1'b0;
        req_bus.req_type      = REQ_KEY_DOWN;
        req_bus.source_id     = '0;
        req_bus.key_usage     = '0;
        req_bus.modifier_bits = '0;
        res_bus.ready         = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = 1'b0;
        hold_req              = 1'b0;
        i_rst_n               = 1'b0;
        send_idle_pct         = 14;
        recv_idle_pct         = 68;
        stall_cycles          = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // table corners with the macro off
        send_event(REQ_KEY_DOWN, 2'd0, KEY_A, 8'h00);
        send_event(REQ_KEY_DOWN, 2'd1, KEY_Z, 8'h22);
        send_event(REQ_KEY_DOWN, 2'd2, KEY_F1, 8'h00);
        send_event(REQ_KEY_DOWN, 2'd3, KEY_F12, 8'h00);
        send_event(REQ_KEY_DOWN, 2'd0, KEY_F1, 8'h11);
        send_event(REQ_KEY_DOWN, 2'd0, 8'h25, 8'h33);
        send_event(REQ_KEY_DOWN, 2'd1, 8'h28, 8'h20);
        send_event(REQ_KEY_DOWN, 2'd1, 8'h23, 8'h02);
        send_event(REQ_KEY_DOWN, 2'd2, 8'h00, 8'h00);
        send_event(REQ_KEY_DOWN, 2'd3, 8'hFF, 8'hFF);
        send_event(REQ_KEY_DOWN, 2'd0, KEY_BKSP, 8'h00);
        // halt hold, repeat, release by other source and by the holder
        send_event(REQ_KEY_DOWN, 2'd0, KEY_ESC, 8'hFF);
        send_event(REQ_KEY_DOWN, 2'd0, KEY_ESC, 8'h00);
        send_event(REQ_KEY_UP, 2'd1, KEY_ESC, 8'h00);
        send_event(REQ_KEY_UP, 2'd0, KEY_A, 8'h00);
        send_event(REQ_KEY_UP, 2'd0, KEY_ESC, 8'h00);
        // disconnect with and without a hold
        send_event(REQ_KEY_DOWN, 2'd3, KEY_ESC, 8'h00);
        send_event(REQ_DISCONNECT, 2'd3, 8'hFF, 8'h00);
        send_event(REQ_DISCONNECT, 2'd3, 8'h00, 8'hFF);
        // emergency release clears holds of every source
        send_event(REQ_KEY_DOWN, 2'd2, KEY_ESC, 8'h00);
        send_event(REQ_KEY_DOWN, 2'd1, KEY_ESC, 8'h00);
        send_event(REQ_EMERGENCY, 2'd3, 8'hFF, 8'hFF);
        send_event(REQ_KEY_UP, 2'd2, KEY_ESC, 8'h00);

        // backspace macro on
        write_macro_enable(1'b1);
        send_event(REQ_KEY_DOWN, 2'd0, KEY_BKSP, 8'h00);
        send_event(REQ_KEY_DOWN, 2'd3, KEY_BKSP, 8'hFF);
        send_event(REQ_KEY_DOWN, 2'd1, 8'h2E, 8'h02);

        // sender idles rarely, receiver often
        for (int n = 0; n < EVENTS_PER_PHASE; n++) send_random_event();

        // the other way round, macro off
        write_macro_enable(1'b0);
        send_idle_pct = 68;
        recv_idle_pct <= 14;
        for (int n = 0; n < EVENTS_PER_PHASE; n++) send_random_event();

        // no idling, one long receiver hold-off while events keep coming
        write_macro_enable(1'b1);
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
            if (n == HOLD_AT_EVENT) hold_req <= ~hold_req;
            send_random_event();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/hkm_pkg.sv
rtl/core/hkm_in_if.sv
rtl/core/hkm_out_if.sv
rtl/core/hkm_front.sv
rtl/core/hkm_queue.sv
rtl/core/hkm_back.sv
rtl/core/hid_key_to_matrix_crosspoint.sv
verif/hkm_drive_checker.sv
verif/testbench.sv
